/* hdl/detection_track_confirm_filter_core_macros.svh */
`ifndef DETECTION_TRACK_CONFIRM_FILTER_CORE_MACROS_SVH
`define DETECTION_TRACK_CONFIRM_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define DTCF_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("dtcf assertion failed");

// next-cycle implication, disabled while reset is held
`define DTCF_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("dtcf assertion failed");

`endif

/* hdl/dtcf_pkg.sv */
package dtcf_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_REQUIRED_HITS = 2'd0;
    localparam logic [1:0] REG_MATCH_RADIUS  = 2'd1;
    localparam logic [1:0] REG_MAX_AGE_MS    = 2'd2;

    localparam logic [3:0]  RESET_REQUIRED_HITS = 4'd2;
    localparam logic [15:0] RESET_MATCH_RADIUS  = 16'd2240;
    localparam logic [15:0] RESET_MAX_AGE_MS    = 16'd200;

    localparam logic KIND_CANDIDATE    = 1'b0;
    localparam logic KIND_END_OF_FRAME = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* hdl/detection_track_confirm_filter_core.sv */
// Channel      Handshake                 Payload
// ----------   -----------------------   ---------------------------------------------
// input        start & !busy             kind, frame_time_ms, class_id, box_x, box_y
// result       result_valid (1 cycle)    publish, hit_count, matched, match_slot,
//                                        table_full
// config       psel & penable & pwrite   paddr, pwdata (prdata on reads, pready = 1)
//
// A candidate holds busy from its accepting edge until its result, scanning the N previous-frame
// tracks (N is zero for a stale or empty bank or in pass-through): one read per cycle, two
// compare stages, a check that the scan has drained, then the write-back (FINISH) state.
// End of frame is handled without leaving idle; busy stays low.
// Reset is asynchronous, active low, and empties both track banks by count.
// The receiver cannot stall: result_valid is high for exactly one cycle per result.
`include "detection_track_confirm_filter_core_macros.svh"

module detection_track_confirm_filter_core #(
    parameter int MAX_TRACKS = 32,
    parameter int CLASS_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [31:0]                       frame_time_ms,
    input  logic [7:0]                        class_id,
    input  logic [15:0]                       box_x,
    input  logic [15:0]                       box_y,
    output logic                              result_valid,
    output logic                              publish,
    output logic [3:0]                        hit_count,
    output logic                              matched,
    output logic [4:0]                        match_slot,
    output logic                              table_full,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dtcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dtcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dtcf_pkg::*;

    localparam int IDX_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TRACKS + 1);
    localparam int CLS_W  = (CLASS_BITS < 8) ? CLASS_BITS : 8;
    localparam int ENT_W  = CLS_W + 36;
    localparam int MEM_D  = 2 << IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKS);

    // configuration
    logic [3:0]  required_hits_reg;
    logic [15:0] match_radius_reg;
    logic [15:0] max_age_ms_reg;
    logic        cfg_wr;

    // bank state
    logic             bank_reg;
    logic [CNT_W-1:0] old_count_reg;
    logic [CNT_W-1:0] new_count_reg;
    logic [31:0]      old_time_reg;

    // candidate
    logic [CLS_W-1:0] cls_reg;
    logic [15:0]      cx_reg;
    logic [15:0]      cy_reg;
    logic             filt_reg;

    // scan
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] scan_len_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             issue;
    logic             accept;
    logic             scan_done;

    logic             p1_valid_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic [ENT_W-1:0] rd_data_reg;

    logic             p2_valid_reg;
    logic             p2_cls_ok_reg;
    logic [31:0]      dx2_reg;
    logic [31:0]      dy2_reg;
    logic [3:0]       p2_hits_reg;
    logic [IDX_W-1:0] p2_idx_reg;

    logic [32:0]      best_d_reg;
    logic [3:0]       best_hits_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             match_reg;

    // memory
    logic [ENT_W-1:0] mem [MEM_D];
    logic [IDX_W:0]   rd_addr;
    logic [IDX_W:0]   wr_addr;
    logic [ENT_W-1:0] wr_data;
    logic             wr_en;

    // datapath
    logic [31:0]      age;
    logic             age_ok;
    logic [31:0]      rad_sq;
    logic [CLS_W-1:0] m_cls;
    logic [15:0]      m_cx;
    logic [15:0]      m_cy;
    logic [15:0]      dx;
    logic [15:0]      dy;
    logic [32:0]      d_sq;
    logic             better;
    logic [4:0]       hits_inc;
    logic [3:0]       fin_hits;
    logic             fin_full;
    logic             fin_pub;
    logic [31:0]      idx_ext;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_hits_reg <= RESET_REQUIRED_HITS;
            match_radius_reg  <= RESET_MATCH_RADIUS;
            max_age_ms_reg    <= RESET_MAX_AGE_MS;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_REQUIRED_HITS: required_hits_reg <= pwdata[3:0];
                REG_MATCH_RADIUS:  match_radius_reg  <= pwdata[15:0];
                REG_MAX_AGE_MS:    max_age_ms_reg    <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_REQUIRED_HITS: prdata = {28'd0, required_hits_reg};
            REG_MATCH_RADIUS:  prdata = {16'd0, match_radius_reg};
            REG_MAX_AGE_MS:    prdata = {16'd0, max_age_ms_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    assign accept    = start & ~busy;
    assign scan_done = ~issue & ~p1_valid_reg & ~p2_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_CANDIDATE)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy  = 1'b1;
        issue = 1'b0;
        wr_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:   busy  = 1'b0;
            ST_SCAN:   issue = (rd_idx_reg < scan_len_reg);
            ST_FINISH: wr_en = filt_reg & ~fin_full;
            default:   busy  = 1'b1;
        endcase
    end

    assign age    = frame_time_ms - old_time_reg;
    assign age_ok = (age <= {16'd0, max_age_ms_reg});
    assign rad_sq = {16'd0, match_radius_reg} * {16'd0, match_radius_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            old_count_reg <= '0;
            new_count_reg <= '0;
            old_time_reg  <= '0;
            rd_idx_reg    <= '0;
            scan_len_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            result_valid  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            result_valid <= (state_reg == ST_FINISH);
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (accept)
            begin
                if (kind == KIND_END_OF_FRAME)
                begin
                    // swap banks only while filtering
                    if (required_hits_reg > 4'd1)
                    begin
                        bank_reg      <= ~bank_reg;
                        old_count_reg <= new_count_reg;
                        old_time_reg  <= frame_time_ms;
                    end
                    new_count_reg <= '0;
                end
                else
                begin
                    rd_idx_reg   <= '0;
                    scan_len_reg <= (required_hits_reg > 4'd1 && age_ok) ? old_count_reg : '0;
                end
            end
            if (wr_en)
            begin
                new_count_reg <= new_count_reg + 1'b1;
            end
        end
    end

    // ---------------- track memory ----------------
    assign rd_addr = {bank_reg, rd_idx_reg[IDX_W-1:0]};
    assign wr_addr = {~bank_reg, new_count_reg[IDX_W-1:0]};
    assign wr_data = {cls_reg, cx_reg, cy_reg, fin_hits};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // ---------------- compare pipeline ----------------
    assign m_cls = rd_data_reg[ENT_W-1 -: CLS_W];
    assign m_cx  = rd_data_reg[35:20];
    assign m_cy  = rd_data_reg[19:4];
    assign dx    = (cx_reg >= m_cx) ? (cx_reg - m_cx) : (m_cx - cx_reg);
    assign dy    = (cy_reg >= m_cy) ? (cy_reg - m_cy) : (m_cy - cy_reg);
    assign d_sq  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign better = p2_valid_reg & p2_cls_ok_reg & (d_sq <= best_d_reg);

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_CANDIDATE)
        begin
            cls_reg    <= class_id[CLS_W-1:0];
            cx_reg     <= box_x;
            cy_reg     <= box_y;
            filt_reg   <= (required_hits_reg > 4'd1);
            best_d_reg <= {1'b0, rad_sq};
            match_reg  <= 1'b0;
        end
        else if (better)
        begin
            // later entry wins on a tie
            best_d_reg    <= d_sq;
            best_hits_reg <= p2_hits_reg;
            best_idx_reg  <= p2_idx_reg;
            match_reg     <= 1'b1;
        end
        p1_idx_reg    <= rd_idx_reg[IDX_W-1:0];
        p2_idx_reg    <= p1_idx_reg;
        p2_cls_ok_reg <= (m_cls == cls_reg);
        p2_hits_reg   <= rd_data_reg[3:0];
        dx2_reg       <= {16'd0, dx} * {16'd0, dx};
        dy2_reg       <= {16'd0, dy} * {16'd0, dy};
    end

    // ---------------- result ----------------
    assign hits_inc = {1'b0, best_hits_reg} + 5'd1;
    assign fin_full = filt_reg & (new_count_reg >= MAX_CNT);
    assign idx_ext  = 32'(best_idx_reg);

    always_comb
    begin
        fin_hits = 4'd1;
        if (filt_reg && match_reg)
        begin
            fin_hits = (hits_inc < {1'b0, required_hits_reg}) ? hits_inc[3:0]
                                                               : required_hits_reg;
        end
        fin_pub = ~filt_reg | (fin_hits >= required_hits_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            publish    <= fin_pub;
            hit_count  <= fin_hits;
            matched    <= filt_reg & match_reg;
            match_slot <= (filt_reg && match_reg) ? idx_ext[4:0] : 5'd0;
            table_full <= fin_full;
        end
    end

    // ---------------- assertions ----------------
    `DTCF_ASSERT_NEXT(a_finish_strobe, clk, rst_n, state_reg == ST_FINISH, result_valid)
    `DTCF_ASSERT_NOW(a_nomatch_hits, clk, rst_n, result_valid && !matched,
        hit_count == 4'd1 && match_slot == 5'd0)
    `DTCF_ASSERT_NEXT(a_cand_busy, clk, rst_n, accept && kind == KIND_CANDIDATE, busy)
    `DTCF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        new_count_reg <= MAX_CNT && old_count_reg <= MAX_CNT)

endmodule
